// ===== hw/rtl/tcsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console screen buffer: shared definitions
// Screen geometry defaults, cell layout, operation codes, and the character
// codes that the console gives special meaning.
// ----------------------------------------------------------------------------
package tcsb_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int LINES_DEF   = 25;

    // Reset values of the configuration registers.
    localparam logic [63:0] COLOR_MAP_RST     = 64'h0;
    localparam logic [3:0]  DEFAULT_COLOR_RST = 4'hF;

    // Configuration register indexes.
    localparam logic REG_COLOR_MAP     = 1'b0;
    localparam logic REG_DEFAULT_COLOR = 1'b1;

    // Characters with a special meaning for put_byte.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'd27;

    // ANSI color code ranges: normal and bright foreground.
    localparam logic [6:0] ANSI_FG_LO     = 7'd30;
    localparam logic [6:0] ANSI_FG_HI     = 7'd37;
    localparam logic [6:0] ANSI_BRIGHT_LO = 7'd90;
    localparam logic [6:0] ANSI_BRIGHT_HI = 7'd97;

    // One cell of the screen: color in the upper nibble, character below.
    typedef struct packed {
        logic [3:0] color;
        logic [7:0] ch;
    } cell_t;

    // Console operations.
    typedef enum logic [3:0] {
        OP_PUT_BYTE    = 4'd0,
        OP_CLEAR       = 4'd1,
        OP_MOVE_TO     = 4'd2,
        OP_SET_COLOR   = 4'd3,
        OP_RESET_COLOR = 4'd4,
        OP_UP          = 4'd5,
        OP_DOWN        = 4'd6,
        OP_LEFT        = 4'd7,
        OP_RIGHT       = 4'd8,
        OP_READ_CELL   = 4'd9,
        OP_FULL_RESET  = 4'd10
    } op_t;

endpackage

// ===== hw/rtl/tcsb_store.sv =====
// ----------------------------------------------------------------------------
// Screen cell store
// Simple dual-port synchronous memory: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcsb_store
    import tcsb_pkg::*;
#(
    parameter int DEPTH  = COLUMNS_DEF * LINES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  cell_t             wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output cell_t             rdata
);

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/text_console_screen_buffer.sv =====
// ----------------------------------------------------------------------------
// Text console screen buffer
// Character-cell screen with cursor, pen color and programmable color map,
// driven by already-decoded console operations.
// ----------------------------------------------------------------------------
// The block keeps LINES x COLUMNS cells of an 8-bit character and a 4-bit
// color in one synchronous memory, plus the cursor and the pen color in
// registers. Each item on the input stream is one console operation and
// produces exactly one result item reporting the cursor and pen color after
// the operation, and the addressed cell for read_cell. Operations are handled
// one at a time. Cursor moves, color changes and CR/ESC pass from acceptance
// through S_EXEC and S_DONE to the result; a printed character or backspace
// does the same with one memory write; an in-range read_cell adds S_READ for
// the registered memory read. Clear reads every cell and writes it back with
// its color kept. A line feed or wrap on the last line scrolls the screen:
// (LINES-1)*COLUMNS cells are copied up one line and then the COLUMNS cells
// of the bottom line are blanked, all through the single write port. Full
// reset rewrites all LINES*COLUMNS cells. After reset the block fills all
// LINES*COLUMNS cells with spaces in color 15 and accepts no item during
// that pass; configuration writes are taken at any time. A finished result
// waits in the output register, and the next item is accepted meanwhile;
// the block stalls only when a second result is ready before the first has
// been taken.
// ----------------------------------------------------------------------------
module text_console_screen_buffer
    import tcsb_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int LINES   = LINES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream of console operations.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: byte_in[7:0], row_arg[15:8], col_arg[23:16], move_count[31:24],
    //          color_code[38:32], zero [39]
    input  logic [39:0] s_tdata,
    // s_tuser: opcode[3:0]
    input  logic [3:0]  s_tuser,
    // Output stream of results.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: cell_char[7:0], cell_color[11:8], cursor_col[18:12],
    //          cursor_row[24:19], current_color[28:25], zero [31:29]
    output logic [31:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CELLS  = COLUMNS * LINES;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam logic [CNT_W-1:0] CNT_CELLS     = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_LINE      = CNT_W'(COLUMNS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_COPY,
        S_FILL,
        S_DONE
    } state_t;

    // Control state.
    state_t      state_reg,     state_next;
    logic [63:0] map_reg,       map_next;
    logic [3:0]  dflt_reg,      dflt_next;
    logic [6:0]  cur_x_reg,     cur_x_next;
    logic [5:0]  cur_y_reg,     cur_y_next;
    logic [3:0]  pen_reg,       pen_next;
    logic [CNT_W-1:0] src_reg,  src_next;
    logic [CNT_W-1:0] dst_reg,  dst_next;
    logic        pend_reg,      pend_next;
    logic        scroll_reg,    scroll_next;
    logic [3:0]  fill_reg,      fill_next;
    logic        m_tvalid_reg,  m_tvalid_next;

    // Latched item and result payload.
    logic [3:0]  op_reg,        op_next;
    logic [7:0]  byte_reg,      byte_next;
    logic [7:0]  row_reg,       row_next;
    logic [7:0]  col_reg,       col_next;
    logic [7:0]  cnt_reg,       cnt_next;
    logic [6:0]  code_reg,      code_next;
    logic [7:0]  rd_char_reg,   rd_char_next;
    logic [3:0]  rd_color_reg,  rd_color_next;
    logic [31:0] m_tdata_reg,   m_tdata_next;

    // Memory ports.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    cell_t             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    cell_t             mem_rdata;

    tcsb_store #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Address of the cell under the cursor, or one to its left for backspace.
    logic [6:0]        wr_col;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] read_addr;
    logic              read_ok;
    logic [3:0]        slot;
    logic              slot_ok;

    assign wr_col      = (byte_reg == CH_BS) ? (cur_x_reg - 7'd1) : cur_x_reg;
    assign cursor_addr = ADDR_W'(int'(cur_y_reg) * COLUMNS + int'(wr_col));
    assign read_ok     = (int'(row_reg) < LINES) && (int'(col_reg) < COLUMNS);
    assign read_addr   = ADDR_W'(int'(row_reg) * COLUMNS + int'(col_reg));

    // The color map holds normal colors in slots 0-7 and bright ones in 8-15.
    always_comb
    begin
        slot    = 4'd0;
        slot_ok = 1'b0;
        if (code_reg >= ANSI_FG_LO && code_reg <= ANSI_FG_HI)
        begin
            slot    = 4'(code_reg - ANSI_FG_LO);
            slot_ok = 1'b1;
        end
        else if (code_reg >= ANSI_BRIGHT_LO && code_reg <= ANSI_BRIGHT_HI)
        begin
            slot    = 4'(code_reg - ANSI_BRIGHT_LO) + 4'd8;
            slot_ok = 1'b1;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        map_next      = map_reg;
        dflt_next     = dflt_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        pen_next      = pen_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        pend_next     = pend_reg;
        scroll_next   = scroll_reg;
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg;
        op_next       = op_reg;
        byte_next     = byte_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        code_next     = code_reg;
        rd_char_next  = rd_char_reg;
        rd_color_next = rd_color_reg;
        m_tdata_next  = m_tdata_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_COLOR_MAP:     map_next  = cfg_data;
                REG_DEFAULT_COLOR: dflt_next = cfg_data[3:0];
                default:           ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_INIT, S_FILL:
            begin
                // Write a blank cell each cycle up to the end of the store.
                mem_we    = 1'b1;
                mem_waddr = dst_reg[ADDR_W-1:0];
                mem_wdata = '{color: fill_reg, ch: CH_SPACE};
                dst_next  = dst_reg + 1'b1;
                if (dst_reg == CNT_LAST)
                begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = s_tuser;
                    byte_next     = s_tdata[7:0];
                    row_next      = s_tdata[15:8];
                    col_next      = s_tdata[23:16];
                    cnt_next      = s_tdata[31:24];
                    code_next     = s_tdata[38:32];
                    rd_char_next  = 8'd0;
                    rd_color_next = 4'd0;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_PUT_BYTE:
                    begin
                        if (byte_reg == CH_CR || byte_reg == CH_ESC)
                        begin
                            state_next = S_DONE;
                        end
                        else if (byte_reg == CH_BS)
                        begin
                            if (cur_x_reg != 7'd0)
                            begin
                                cur_x_next = cur_x_reg - 7'd1;
                                mem_we     = 1'b1;
                                mem_waddr  = cursor_addr;
                                mem_wdata  = '{color: pen_reg, ch: CH_SPACE};
                            end
                        end
                        else
                        begin
                            if (byte_reg != CH_LF)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_addr;
                                mem_wdata = '{color: pen_reg, ch: byte_reg};
                            end
                            if (byte_reg != CH_LF && int'(cur_x_reg) + 1 < COLUMNS)
                            begin
                                cur_x_next = cur_x_reg + 7'd1;
                            end
                            else
                            begin
                                // New line; on the last line scroll the screen up.
                                cur_x_next = 7'd0;
                                if (int'(cur_y_reg) + 1 < LINES)
                                begin
                                    cur_y_next = cur_y_reg + 6'd1;
                                end
                                else
                                begin
                                    src_next    = CNT_LINE;
                                    dst_next    = '0;
                                    pend_next   = 1'b0;
                                    scroll_next = 1'b1;
                                    state_next  = S_COPY;
                                end
                            end
                        end
                    end

                    OP_CLEAR:
                    begin
                        src_next    = '0;
                        dst_next    = '0;
                        pend_next   = 1'b0;
                        scroll_next = 1'b0;
                        state_next  = S_COPY;
                    end

                    OP_MOVE_TO:
                    begin
                        if (row_reg != 8'd0 && col_reg != 8'd0
                            && int'(row_reg) <= LINES && int'(col_reg) <= COLUMNS)
                        begin
                            cur_y_next = 6'(row_reg - 8'd1);
                            cur_x_next = 7'(col_reg - 8'd1);
                        end
                    end

                    OP_SET_COLOR:
                    begin
                        if (slot_ok)
                        begin
                            pen_next = map_reg[{slot, 2'b00} +: 4];
                        end
                    end

                    OP_RESET_COLOR:
                    begin
                        pen_next = dflt_reg;
                    end

                    OP_UP:
                    begin
                        if ({2'b00, cur_y_reg} >= cnt_reg)
                        begin
                            cur_y_next = cur_y_reg - 6'(cnt_reg);
                        end
                    end

                    OP_DOWN:
                    begin
                        if (int'(cur_y_reg) + int'(cnt_reg) < LINES)
                        begin
                            cur_y_next = cur_y_reg + 6'(cnt_reg);
                        end
                    end

                    OP_LEFT:
                    begin
                        if ({1'b0, cur_x_reg} >= cnt_reg)
                        begin
                            cur_x_next = cur_x_reg - 7'(cnt_reg);
                        end
                    end

                    OP_RIGHT:
                    begin
                        if (int'(cur_x_reg) + int'(cnt_reg) < COLUMNS)
                        begin
                            cur_x_next = cur_x_reg + 7'(cnt_reg);
                        end
                    end

                    OP_READ_CELL:
                    begin
                        if (read_ok)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = read_addr;
                            state_next = S_READ;
                        end
                    end

                    OP_FULL_RESET:
                    begin
                        cur_x_next = 7'd0;
                        cur_y_next = 6'd0;
                        pen_next   = dflt_reg;
                        fill_next  = dflt_reg;
                        dst_next   = '0;
                        state_next = S_FILL;
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_READ:
            begin
                rd_char_next  = mem_rdata.ch;
                rd_color_next = mem_rdata.color;
                state_next    = S_DONE;
            end

            S_COPY:
            begin
                // Each cell is written in the cycle after it is read; for a scroll the
                // read is a line ahead, for a clear it is the same cell.
                if (src_reg != CNT_CELLS)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg[ADDR_W-1:0];
                    src_next  = src_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg[ADDR_W-1:0];
                    mem_wdata = mem_rdata;
                    if (!scroll_reg)
                    begin
                        mem_wdata.ch = CH_SPACE;
                    end
                    dst_next  = dst_reg + 1'b1;
                end
                if (src_reg == CNT_CELLS && !pend_reg)
                begin
                    if (scroll_reg)
                    begin
                        // Blank the new bottom line in the pen color.
                        fill_next  = pen_reg;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, pen_reg, cur_y_reg, cur_x_reg,
                                     rd_color_reg, rd_char_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            map_reg      <= COLOR_MAP_RST;
            dflt_reg     <= DEFAULT_COLOR_RST;
            cur_x_reg    <= 7'd0;
            cur_y_reg    <= 6'd0;
            pen_reg      <= DEFAULT_COLOR_RST;
            src_reg      <= '0;
            dst_reg      <= '0;
            pend_reg     <= 1'b0;
            scroll_reg   <= 1'b0;
            fill_reg     <= DEFAULT_COLOR_RST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            map_reg      <= map_next;
            dflt_reg     <= dflt_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            pen_reg      <= pen_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            pend_reg     <= pend_next;
            scroll_reg   <= scroll_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        byte_reg     <= byte_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        cnt_reg      <= cnt_next;
        code_reg     <= code_next;
        rd_char_reg  <= rd_char_next;
        rd_color_reg <= rd_color_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The cursor always stays on the screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_x_reg) < COLUMNS) && (int'(cur_y_reg) < LINES))
        else $error("cursor left the screen");

    // A pass never reads the cell it writes in the same cycle.
    a_no_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("store read and written at the same cell");

    // An accepted item goes straight to execution.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the text console screen buffer
// Streams decoded console operations into the block, predicts every result
// item from a shadow copy of the screen, cursor and pen, and compares each
// result field by field. Both stream sides stall in random bursts, and the
// color map and default color are reprogrammed between phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcsb_pkg::*;

    // Screen geometry of the instance (the block's defaults).
    localparam int NCOLS  = COLUMNS_DEF;
    localparam int NROWS  = LINES_DEF;
    localparam int NCELLS = NCOLS * NROWS;

    // Bright color codes select the upper eight nibbles of the color map.
    localparam int BRIGHT_SLOT_BASE = 8;

    // Highest value of the opcode field; codes above OP_FULL_RESET do nothing.
    localparam logic [3:0] OP_CODE_MAX = 4'hF;

    // The slowest correct run has every item scroll or rewrite the whole
    // store behind a GAP_MAX gap on each side, plus the clearing pass after
    // reset. The limit takes that several times over.
    localparam int LIMIT_CYCLES = 12_000_000;

    // Cycles to watch for stray result items once everything has arrived.
    localparam int DRAIN_CYCLES = 50;

    // Burst length bounds for idling on either side.
    localparam int GAP_MIN = 1;
    localparam int GAP_MAX = 18;

    // Only the first few mismatches are printed in detail.
    localparam int REPORT_MAX = 10;

    // One console operation as it travels on the input stream.
    typedef struct {
        logic [3:0] opcode;
        logic [7:0] byte_in;
        logic [7:0] row_arg;
        logic [7:0] col_arg;
        logic [7:0] move_count;
        logic [6:0] color_code;
    } console_op_t;

    // One result item as it travels on the output stream.
    typedef struct {
        logic [7:0] cell_char;
        logic [3:0] cell_color;
        logic [6:0] cursor_col;
        logic [5:0] cursor_row;
        logic [3:0] current_color;
    } screen_report_t;

    // Ports of the block. Every input has a known value from time zero.
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata    = '0;
    logic [3:0]  s_tuser    = '0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we     = 1'b0;
    logic        cfg_index  = 1'b0;
    logic [63:0] cfg_data   = '0;

    // Shadow copy of the block's state and registers.
    cell_t       shadow_screen [NCELLS];
    int          cur_col;
    int          cur_row;
    logic [3:0]  pen;
    logic [63:0] map_reg;
    logic [3:0]  default_reg;

    // Operations waiting for the driver, and reports that the block owes us.
    console_op_t    pending_ops [$];
    screen_report_t screen_forecast [$];
    int             unanswered_ops = 0;

    // Driver state.
    console_op_t offer;
    logic        offer_taken = 1'b0;
    int          send_gap    = 0;
    int          send_calm   = 0;

    // Receiver state.
    int recv_gap  = 0;
    int recv_calm = 0;

    // The last part of the run goes at full speed on both sides.
    logic quiet_tail = 1'b0;

    // Failure bookkeeping.
    int             fault_count = 0;
    int             result_count = 0;
    screen_report_t got;
    screen_report_t want;

    text_console_screen_buffer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void fill_screen(input logic [3:0] color);
        int i;
        for (i = 0; i < NCELLS; i++)
            shadow_screen[i] = {color, CH_SPACE};
    endfunction

    // Cursor to the start of the next line. On the last line the whole
    // screen moves up one line and the new bottom line is blanked in the pen.
    function automatic void advance_line();
        int i;
        cur_col = 0;
        if (cur_row + 1 < NROWS)
            cur_row++;
        else
        begin
            for (i = 0; i < NCELLS - NCOLS; i++)
                shadow_screen[i] = shadow_screen[i + NCOLS];
            for (i = NCELLS - NCOLS; i < NCELLS; i++)
                shadow_screen[i] = {pen, CH_SPACE};
            cur_row = NROWS - 1;
        end
    endfunction

    // Applies one accepted operation to the shadow state and returns the
    // result item the block must produce for it.
    function automatic screen_report_t apply_console_op(input console_op_t op);
        screen_report_t rep;
        int row;
        int col;
        int cnt;
        int slot;
        int i;
        row  = op.row_arg;
        col  = op.col_arg;
        cnt  = op.move_count;
        slot = -1;
        rep.cell_char  = '0;
        rep.cell_color = '0;
        case (op.opcode)
            OP_PUT_BYTE:
            begin
                case (op.byte_in)
                    // Carriage return and escape leave everything alone.
                    CH_CR, CH_ESC: ;
                    CH_LF: advance_line();
                    // Backspace erases the cell to the left; nothing at column 0.
                    CH_BS:
                    begin
                        if (cur_col > 0)
                        begin
                            cur_col--;
                            shadow_screen[cur_row * NCOLS + cur_col] = {pen, CH_SPACE};
                        end
                    end
                    default:
                    begin
                        shadow_screen[cur_row * NCOLS + cur_col] = {pen, op.byte_in};
                        if (cur_col + 1 < NCOLS)
                            cur_col++;
                        else
                            advance_line();
                    end
                endcase
            end
            // Clear blanks characters only; colors and cursor stay.
            OP_CLEAR:
            begin
                for (i = 0; i < NCELLS; i++)
                    shadow_screen[i].ch = CH_SPACE;
            end
            OP_MOVE_TO:
            begin
                if (row >= 1 && col >= 1 && row - 1 < NROWS && col - 1 < NCOLS)
                begin
                    cur_row = row - 1;
                    cur_col = col - 1;
                end
            end
            OP_SET_COLOR:
            begin
                if (op.color_code >= ANSI_FG_LO && op.color_code <= ANSI_FG_HI)
                    slot = int'(op.color_code) - int'(ANSI_FG_LO);
                else if (op.color_code >= ANSI_BRIGHT_LO && op.color_code <= ANSI_BRIGHT_HI)
                    slot = int'(op.color_code) - int'(ANSI_BRIGHT_LO) + BRIGHT_SLOT_BASE;
                if (slot >= 0)
                    pen = map_reg[4 * slot +: 4];
            end
            OP_RESET_COLOR: pen = default_reg;
            // Relative moves that would leave the screen are dropped whole.
            OP_UP:
            begin
                if (cnt <= cur_row)
                    cur_row -= cnt;
            end
            OP_DOWN:
            begin
                if (cur_row + cnt < NROWS)
                    cur_row += cnt;
            end
            OP_LEFT:
            begin
                if (cnt <= cur_col)
                    cur_col -= cnt;
            end
            OP_RIGHT:
            begin
                if (cur_col + cnt < NCOLS)
                    cur_col += cnt;
            end
            OP_READ_CELL:
            begin
                if (row < NROWS && col < NCOLS)
                begin
                    rep.cell_char  = shadow_screen[row * NCOLS + col].ch;
                    rep.cell_color = shadow_screen[row * NCOLS + col].color;
                end
            end
            OP_FULL_RESET:
            begin
                cur_col = 0;
                cur_row = 0;
                pen     = default_reg;
                fill_screen(pen);
            end
            default: ;
        endcase
        rep.cursor_col    = 7'(cur_col);
        rep.cursor_row    = 6'(cur_row);
        rep.current_color = pen;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_op(input logic [3:0] opcode, input logic [7:0] byte_in,
                            input logic [7:0] row_arg, input logic [7:0] col_arg,
                            input logic [7:0] move_count, input logic [6:0] color_code);
        console_op_t op;
        op.opcode     = opcode;
        op.byte_in    = byte_in;
        op.row_arg    = row_arg;
        op.col_arg    = col_arg;
        op.move_count = move_count;
        op.color_code = color_code;
        unanswered_ops++;
        pending_ops.push_back(op);
    endtask

    // Registers are only written while the block has nothing in flight, so
    // the shadow copy can take the new value right away.
    task automatic write_register(input logic index, input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == REG_COLOR_MAP)
            map_reg = value;
        else
            default_reg = value[3:0];
    endtask

    task automatic wait_until_answered();
        while (unanswered_ops != 0)
            @(posedge clk);
    endtask

    // Random operations. Unused fields always carry random bits. Most
    // arguments are chosen to land on the screen so that moves, reads and
    // color changes take effect; runs of printable text produce line wraps
    // and, at the bottom, scrolls. Clear and full reset are rare because
    // each one costs a pass over the whole store.
    task automatic queue_random_ops(input int n_items);
        int k;
        int pick;
        int run_left;
        logic [3:0] opc;
        logic [7:0] b;
        logic [7:0] r;
        logic [7:0] c;
        logic [7:0] n;
        logic [6:0] code;
        run_left = 0;
        for (k = 0; k < n_items; k++)
        begin
            b    = 8'($urandom);
            r    = 8'($urandom);
            c    = 8'($urandom);
            n    = 8'($urandom);
            code = 7'($urandom);
            opc  = OP_PUT_BYTE;
            pick = $urandom_range(0, 999);
            if (run_left > 0)
            begin
                run_left--;
                b = 8'($urandom_range(8'h21, 8'h7E));
            end
            else if (pick < 400)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    b = CH_LF;
                else if (pick < 14)
                    b = CH_BS;
                else if (pick < 17)
                    b = CH_CR;
                else if (pick < 20)
                    b = CH_ESC;
            end
            else if (pick < 440)
            begin
                run_left = $urandom_range(5, 60);
                b = 8'($urandom_range(8'h21, 8'h7E));
            end
            else if (pick < 540)
            begin
                opc = OP_MOVE_TO;
                if ($urandom_range(0, 99) < 85)
                begin
                    r = 8'($urandom_range(1, NROWS));
                    c = 8'($urandom_range(1, NCOLS));
                end
            end
            else if (pick < 610)
            begin
                opc = OP_SET_COLOR;
                if ($urandom_range(0, 99) < 80)
                    code = ($urandom_range(0, 1) ? ANSI_FG_LO : ANSI_BRIGHT_LO)
                           + 7'($urandom_range(0, ANSI_FG_HI - ANSI_FG_LO));
            end
            else if (pick < 640)
                opc = OP_RESET_COLOR;
            else if (pick < 800)
            begin
                case ($urandom_range(0, 3))
                    0: opc = OP_UP;
                    1: opc = OP_DOWN;
                    2: opc = OP_LEFT;
                    default: opc = OP_RIGHT;
                endcase
                if ($urandom_range(0, 99) < 75)
                    n = 8'($urandom_range(0, (opc == OP_UP || opc == OP_DOWN) ? NROWS : NCOLS));
            end
            else if (pick < 940)
            begin
                opc = OP_READ_CELL;
                if ($urandom_range(0, 99) < 85)
                begin
                    r = 8'($urandom_range(0, NROWS - 1));
                    c = 8'($urandom_range(0, NCOLS - 1));
                end
            end
            else if (pick < 950)
                opc = OP_CLEAR;
            else if (pick < 960)
                opc = OP_FULL_RESET;
            else
                opc = 4'($urandom_range(int'(OP_FULL_RESET) + 1, int'(OP_CODE_MAX)));
            queue_op(opc, b, r, c, n, code);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents pending operations on the input stream. Inputs change
    // on the falling edge; acceptance is seen on the rising edge.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            screen_forecast.push_back(apply_console_op(offer));
            offer_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || offer_taken))
        begin
            offer_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() != 0 && !quiet_tail && send_calm == 0
                     && $urandom_range(0, 99) < 15)
            begin
                // This cycle is the first of the burst.
                send_gap = $urandom_range(GAP_MIN, GAP_MAX) - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                offer = pending_ops.pop_front();
                if (send_calm > 0)
                    send_calm--;
                else if ($urandom_range(0, 99) < 2)
                    send_calm = $urandom_range(10, 60);
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, offer.color_code, offer.move_count, offer.col_arg,
                             offer.row_arg, offer.byte_in};
                s_tuser  <= offer.opcode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result items and checks them against the forecast.
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (recv_calm > 0)
            recv_calm--;
        else if (!quiet_tail && $urandom_range(0, 999) < 5)
            recv_calm = $urandom_range(50, 300);
        if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 99) < 10)
        begin
            recv_gap = $urandom_range(GAP_MIN, GAP_MAX) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            got.cell_char     = m_tdata[7:0];
            got.cell_color    = m_tdata[11:8];
            got.cursor_col    = m_tdata[18:12];
            got.cursor_row    = m_tdata[24:19];
            got.current_color = m_tdata[28:25];
            if (screen_forecast.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("result item %0d arrived with nothing expected: tdata %h",
                             result_count, m_tdata);
            end
            else
            begin
                want = screen_forecast.pop_front();
                unanswered_ops--;
                if (got.cell_char !== want.cell_char || got.cell_color !== want.cell_color
                    || got.cursor_col !== want.cursor_col
                    || got.cursor_row !== want.cursor_row
                    || got.current_color !== want.current_color)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                    begin
                        $write("result item %0d mismatch (expected/actual): char %h/%h ",
                               result_count, want.cell_char, got.cell_char);
                        $display("color %h/%h col %0d/%0d row %0d/%0d pen %h/%h",
                                 want.cell_color, got.cell_color,
                                 want.cursor_col, got.cursor_col,
                                 want.cursor_row, got.cursor_row,
                                 want.current_color, got.current_color);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a hang anywhere ends the run as a failure.
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        // State after reset: blank screen in color 15, cursor home.
        map_reg     = COLOR_MAP_RST;
        default_reg = DEFAULT_COLOR_RST;
        pen         = DEFAULT_COLOR_RST;
        cur_col     = 0;
        cur_row     = 0;
        fill_screen(DEFAULT_COLOR_RST);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Phase 0: distinct nibbles in the map, so code 30 gives 15 and
        // code 97 gives 0; default color at its low extreme.
        write_register(REG_COLOR_MAP, 64'h0123_4567_89AB_CDEF);
        write_register(REG_DEFAULT_COLOR, 64'h0);

        // Directed items. The store must read back as blank after reset.
        queue_op(OP_READ_CELL, 8'h00, 8'd0, 8'd0, 8'd0, 7'd0);
        // Byte 0 and byte 255 are ordinary characters.
        queue_op(OP_PUT_BYTE, 8'h00, 8'd0, 8'd0, 8'd0, 7'd0);
        queue_op(OP_PUT_BYTE, 8'hFF, 8'd0, 8'd0, 8'd0, 7'd0);
        // Backspace above column 0 erases; CR and ESC do nothing.
        queue_op(OP_PUT_BYTE, CH_BS, 8'd0, 8'd0, 8'd0, 7'd0);
        queue_op(OP_PUT_BYTE, CH_CR, 8'd0, 8'd0, 8'd0, 7'd0);
        queue_op(OP_PUT_BYTE, CH_ESC, 8'd0, 8'd0, 8'd0, 7'd0);
        // Line feed, then backspace at column 0 which must do nothing.
        queue_op(OP_PUT_BYTE, CH_LF, 8'd0, 8'd0, 8'd0, 7'd0);
        queue_op(OP_PUT_BYTE, CH_BS, 8'd0, 8'd0, 8'd0, 7'd0);
        // Move-to with a zero argument and past the edge are both ignored.
        queue_op(OP_MOVE_TO, 8'h00, 8'd0, 8'd5, 8'd0, 7'd0);
        queue_op(OP_MOVE_TO, 8'h00, 8'(NROWS + 1), 8'(NCOLS + 1), 8'd0, 7'd0);
        // Last cell of the screen; printing there wraps and scrolls.
        queue_op(OP_MOVE_TO, 8'h00, 8'(NROWS), 8'(NCOLS), 8'd0, 7'd0);
        queue_op(OP_PUT_BYTE, "A", 8'd0, 8'd0, 8'd0, 7'd0);
        // First normal and last bright code, then an unmapped code.
        queue_op(OP_SET_COLOR, 8'h00, 8'd0, 8'd0, 8'd0, ANSI_FG_LO);
        queue_op(OP_SET_COLOR, 8'h00, 8'd0, 8'd0, 8'd0, ANSI_BRIGHT_HI);
        queue_op(OP_SET_COLOR, 8'h00, 8'd0, 8'd0, 8'd0, 7'h7F);
        // Relative moves: out of range ones are dropped, not clamped.
        queue_op(OP_UP, 8'h00, 8'd0, 8'd0, 8'hFF, 7'd0);
        queue_op(OP_UP, 8'h00, 8'd0, 8'd0, 8'(NROWS - 1), 7'd0);
        queue_op(OP_DOWN, 8'h00, 8'd0, 8'd0, 8'd0, 7'd0);
        queue_op(OP_RIGHT, 8'h00, 8'd0, 8'd0, 8'(NCOLS - 1), 7'd0);
        queue_op(OP_LEFT, 8'h00, 8'd0, 8'd0, 8'hFF, 7'd0);
        queue_op(OP_DOWN, 8'h00, 8'd0, 8'd0, 8'(NROWS - 1), 7'd0);
        // Reads outside the screen give zeros; the scrolled 'A' is one up.
        queue_op(OP_READ_CELL, 8'h00, 8'hFF, 8'hFF, 8'd0, 7'd0);
        queue_op(OP_READ_CELL, 8'h00, 8'(NROWS - 2), 8'(NCOLS - 1), 8'd0, 7'd0);
        // Clear keeps the colors, so the same cell reads a space in 15.
        queue_op(OP_CLEAR, 8'h00, 8'd0, 8'd0, 8'd0, 7'd0);
        queue_op(OP_READ_CELL, 8'h00, 8'(NROWS - 2), 8'(NCOLS - 1), 8'd0, 7'd0);
        queue_op(OP_RESET_COLOR, 8'h00, 8'd0, 8'd0, 8'd0, 7'd0);
        // An unused opcode with every data bit set changes nothing.
        queue_op(OP_CODE_MAX, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h7F);
        queue_op(OP_FULL_RESET, 8'h00, 8'd0, 8'd0, 8'd0, 7'd0);
        wait_until_answered();

        // Phase 1: map and default color at their high extremes.
        write_register(REG_COLOR_MAP, '1);
        write_register(REG_DEFAULT_COLOR, 64'hF);
        queue_random_ops(250);
        wait_until_answered();

        // Phase 2: map all zero, random default color.
        write_register(REG_COLOR_MAP, '0);
        write_register(REG_DEFAULT_COLOR, 64'($urandom_range(0, 15)));
        queue_random_ops(250);
        wait_until_answered();

        // Phase 3: random map and default color.
        write_register(REG_COLOR_MAP, {$urandom, $urandom});
        write_register(REG_DEFAULT_COLOR, 64'($urandom_range(0, 15)));
        queue_random_ops(300);
        wait_until_answered();

        // Phase 4: random settings again, both sides at full speed.
        write_register(REG_COLOR_MAP, {$urandom, $urandom});
        write_register(REG_DEFAULT_COLOR, 64'($urandom_range(0, 15)));
        quiet_tail = 1'b1;
        queue_random_ops(350);
        wait_until_answered();

        // Give a stray extra result item the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && screen_forecast.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
